// ===== rtl/sdsc_pkg.sv =====
// Shared types and constants for the stove draft state controller.
// Holds the state, timer, configuration, item and result types.
// No dependencies.
package sdsc_pkg;

  // Field widths.
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned SETPT_W  = 11;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned SEC_W    = 16;
  localparam int unsigned SPEED_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Fixed timer lengths in seconds.
  localparam logic [SEC_W-1:0] BOOST_SECONDS     = 16'd300;
  localparam logic [SEC_W-1:0] FUEL_BEEP_SECONDS = 16'd600;

  // Configuration reset values.
  localparam logic [SETPT_W-1:0]  RST_IDLE_TEMP  = 11'd300;
  localparam logic [SETPT_W-1:0]  RST_RUN_TEMP   = 11'd450;
  localparam logic [SETPT_W-1:0]  RST_ALARM_TEMP = 11'd900;
  localparam logic [SETPT_W-1:0]  RST_MIN_DRAFT  = 11'd150;
  localparam logic [OFFSET_W-1:0] RST_DYING_OFF  = 10'd50;
  localparam logic [SEC_W-1:0]    RST_FLUE_WAIT  = 16'd1800;
  localparam logic [SEC_W-1:0]    RST_COLD_WAIT  = 16'd3600;
  localparam logic [SPEED_W-1:0]  RST_IDLE_SPEED = 8'd0;

  typedef enum logic [2:0] {
    ST_NOFIRE = 3'd0,
    ST_IDLE   = 3'd1,
    ST_RUN    = 3'd2,
    ST_DYING  = 3'd3,
    ST_ALARM  = 3'd4,
    ST_BOOST  = 3'd5
  } fsm_state_e;

  // Stored draft drive setting.
  typedef enum logic [1:0] {
    DR_STOP = 2'd0,
    DR_IDLE = 2'd1,
    DR_RUN  = 2'd2,
    DR_FULL = 2'd3
  } drive_e;

  // Reported drive mode, including the idle override speed.
  typedef enum logic [2:0] {
    DM_STOP     = 3'd0,
    DM_IDLE     = 3'd1,
    DM_RUN      = 3'd2,
    DM_FULL     = 3'd3,
    DM_OVERRIDE = 3'd4
  } drive_mode_e;

  typedef enum logic [1:0] {
    BP_OFF   = 2'd0,
    BP_FUEL  = 2'd1,
    BP_ALARM = 2'd2
  } beeper_e;

  typedef enum logic [1:0] {
    AK_NONE      = 2'd0,
    AK_BAD_PROBE = 2'd1,
    AK_OVER_TEMP = 2'd2
  } alarm_e;

  typedef enum logic [1:0] {
    TM_NOTSET  = 2'd0,
    TM_RUNNING = 2'd1,
    TM_EXPIRED = 2'd2
  } tm_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_TEMP  = 3'd0,
    CFG_RUN_TEMP   = 3'd1,
    CFG_ALARM_TEMP = 3'd2,
    CFG_MIN_DRAFT  = 3'd3,
    CFG_DYING_OFF  = 3'd4,
    CFG_FLUE_WAIT  = 3'd5,
    CFG_COLD_WAIT  = 3'd6,
    CFG_IDLE_SPEED = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [SEC_W-1:0] count;
    tm_status_e       status;
  } timer_t;

  typedef struct packed {
    logic [SETPT_W-1:0]  target_idle_temp;
    logic [SETPT_W-1:0]  target_run_temp;
    logic [SETPT_W-1:0]  alarm_flue_temp;
    logic [SETPT_W-1:0]  min_draft_temp;
    logic [OFFSET_W-1:0] dying_fire_offset;
    logic [SEC_W-1:0]    flue_wait_seconds;
    logic [SEC_W-1:0]    cold_start_wait_seconds;
    logic [SPEED_W-1:0]  idle_override_speed;
  } cfg_t;

  typedef struct packed {
    fsm_state_e               fsm;
    logic                     cold_start;
    logic                     boost_latched;
    logic                     dying_alarm_armed;
    logic signed [TEMP_W-1:0] lowest_dying_temp;
    timer_t                   flue;
    timer_t                   boost;
    timer_t                   fuel;
    drive_e                   drive;
    beeper_e                  beeper;
    logic                     fan_force;
  } ctrl_state_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] flue_temp;
    logic                     probe_valid;
    logic                     heat_call;
    logic                     boost_button;
    logic                     mute_button;
  } item_t;

  typedef struct packed {
    fsm_state_e  ctrl_state;
    drive_mode_e drive_mode;
    beeper_e     beeper_mode;
    logic        fan_force_on;
    alarm_e      alarm_kind;
    logic        mute_request;
  } result_t;

endpackage

// ===== rtl/sdsc_step.sv =====
// One-tick update of the draft state machine and its timers.
// Purely combinational: current state and one item in, next state and result out.
// Depends on sdsc_pkg.
module sdsc_step (
  input  sdsc_pkg::cfg_t        cfg_i,
  input  sdsc_pkg::ctrl_state_t state_i,
  input  sdsc_pkg::item_t       item_i,
  output sdsc_pkg::ctrl_state_t state_o,
  output sdsc_pkg::result_t     result_o
);

  // A running timer counts down once per tick and expires on reaching zero.
  function automatic sdsc_pkg::timer_t tm_tick(sdsc_pkg::timer_t t);
    sdsc_pkg::timer_t r;
    r = t;
    if (t.status == sdsc_pkg::TM_RUNNING) begin
      if (t.count <= 16'd1) begin
        r.count  = '0;
        r.status = sdsc_pkg::TM_EXPIRED;
      end else begin
        r.count = t.count - 16'd1;
      end
    end
    return r;
  endfunction

  function automatic sdsc_pkg::timer_t tm_start(logic [sdsc_pkg::SEC_W-1:0] secs);
    sdsc_pkg::timer_t r;
    r.count  = secs;
    r.status = sdsc_pkg::TM_RUNNING;
    return r;
  endfunction

  function automatic sdsc_pkg::timer_t tm_clear();
    sdsc_pkg::timer_t r;
    r.count  = '0;
    r.status = sdsc_pkg::TM_NOTSET;
    return r;
  endfunction

  // A latched boost request either enters air boost or is dropped.
  function automatic sdsc_pkg::ctrl_state_t try_boost(sdsc_pkg::ctrl_state_t s,
                                                      logic cold_enough);
    sdsc_pkg::ctrl_state_t r;
    r = s;
    if (s.boost_latched) begin
      if (cold_enough) begin
        r.drive = sdsc_pkg::DR_FULL;
        if (s.boost.status == sdsc_pkg::TM_NOTSET) begin
          r.boost = tm_start(sdsc_pkg::BOOST_SECONDS);
        end
        r.fsm = sdsc_pkg::ST_BOOST;
      end else begin
        r.boost_latched = 1'b0;
      end
    end
    return r;
  endfunction

  // Temperatures and thresholds widened to 13-bit signed for compares.
  logic signed [12:0] temp;
  logic signed [12:0] off;
  logic signed [12:0] tmin;
  logic signed [12:0] idle_thr;
  logic signed [12:0] run_thr;
  logic signed [12:0] idle_set;
  logic signed [12:0] alarm_set;
  logic signed [12:0] low_d;
  logic [sdsc_pkg::SEC_W-1:0] flue_wait;
  logic                mute_req;
  logic                skip_boost;
  sdsc_pkg::alarm_e    alarm_kind;
  sdsc_pkg::ctrl_state_t n;

  assign temp      = {item_i.flue_temp[sdsc_pkg::TEMP_W-1], item_i.flue_temp};
  assign off       = signed'({3'b000, cfg_i.dying_fire_offset});
  assign tmin      = signed'({2'b00, cfg_i.min_draft_temp});
  assign idle_set  = signed'({2'b00, cfg_i.target_idle_temp});
  assign alarm_set = signed'({2'b00, cfg_i.alarm_flue_temp});
  assign idle_thr  = idle_set - off;
  assign run_thr   = signed'({2'b00, cfg_i.target_run_temp}) - off;
  assign flue_wait = state_i.cold_start ? cfg_i.cold_start_wait_seconds
                                        : cfg_i.flue_wait_seconds;

  // Alarm condition is judged on this tick's input alone.
  always_comb begin
    if (!item_i.probe_valid) begin
      alarm_kind = sdsc_pkg::AK_BAD_PROBE;
    end else if (temp >= alarm_set) begin
      alarm_kind = sdsc_pkg::AK_OVER_TEMP;
    end else begin
      alarm_kind = sdsc_pkg::AK_NONE;
    end
  end

  // Mute and boost buttons act on the state at the start of the tick.
  assign mute_req   = item_i.mute_button && (state_i.fsm == sdsc_pkg::ST_ALARM);
  assign skip_boost = mute_req;

  // Next state: timers, buttons, alarm entry, fuel silence, then the machine.
  always_comb begin
    n       = state_i;
    n.flue  = tm_tick(state_i.flue);
    n.boost = tm_tick(state_i.boost);
    n.fuel  = tm_tick(state_i.fuel);
    low_d   = {state_i.lowest_dying_temp[sdsc_pkg::TEMP_W-1], state_i.lowest_dying_temp};

    if (item_i.mute_button && state_i.fsm == sdsc_pkg::ST_DYING) begin
      n.beeper = sdsc_pkg::BP_OFF;
    end
    if (!skip_boost && item_i.boost_button &&
        (state_i.fsm == sdsc_pkg::ST_NOFIRE || state_i.fsm == sdsc_pkg::ST_IDLE ||
         state_i.fsm == sdsc_pkg::ST_DYING)) begin
      n.boost_latched = 1'b1;
    end

    if (alarm_kind != sdsc_pkg::AK_NONE && n.fsm != sdsc_pkg::ST_ALARM) begin
      n.drive     = sdsc_pkg::DR_STOP;
      n.fan_force = 1'b1;
      n.beeper    = sdsc_pkg::BP_ALARM;
      n.fsm       = sdsc_pkg::ST_ALARM;
    end
    if (n.fsm != sdsc_pkg::ST_ALARM && n.fuel.status == sdsc_pkg::TM_EXPIRED) begin
      n.fuel   = tm_clear();
      n.beeper = sdsc_pkg::BP_OFF;
    end

    unique case (n.fsm)
      sdsc_pkg::ST_IDLE: begin
        if (temp < tmin) begin
          n.drive = sdsc_pkg::DR_STOP;
          n.fsm   = sdsc_pkg::ST_NOFIRE;
        end else if (item_i.heat_call) begin
          n.fuel   = tm_clear();
          n.beeper = sdsc_pkg::BP_OFF;
          n.drive  = sdsc_pkg::DR_RUN;
          n.fsm    = sdsc_pkg::ST_RUN;
        end else begin
          if (n.flue.status == sdsc_pkg::TM_EXPIRED) begin
            if (n.dying_alarm_armed) begin
              n.dying_alarm_armed = 1'b0;
              n.fuel              = tm_start(sdsc_pkg::FUEL_BEEP_SECONDS);
              n.beeper            = sdsc_pkg::BP_FUEL;
            end
            n.drive = sdsc_pkg::DR_STOP;
          end
          if (temp < idle_thr) begin
            if (n.flue.status == sdsc_pkg::TM_NOTSET) begin
              n.flue = tm_start(flue_wait);
            end
          end else begin
            n.flue = tm_clear();
            if (n.fuel.status != sdsc_pkg::TM_NOTSET) begin
              n.fuel   = tm_clear();
              n.beeper = sdsc_pkg::BP_OFF;
            end
          end
          n = try_boost(n, temp < run_thr);
        end
      end
      sdsc_pkg::ST_RUN: begin
        if (!item_i.heat_call) begin
          n.flue              = tm_clear();
          n.dying_alarm_armed = 1'b1;
          n.drive             = sdsc_pkg::DR_IDLE;
          n.fsm               = sdsc_pkg::ST_IDLE;
        end else if (n.flue.status == sdsc_pkg::TM_EXPIRED) begin
          n.flue              = tm_clear();
          n.lowest_dying_temp = item_i.flue_temp;
          n.fuel              = tm_start(sdsc_pkg::FUEL_BEEP_SECONDS);
          n.beeper            = sdsc_pkg::BP_FUEL;
          n.drive             = sdsc_pkg::DR_STOP;
          n.fsm               = sdsc_pkg::ST_DYING;
        end else if (temp < run_thr) begin
          if (n.flue.status == sdsc_pkg::TM_NOTSET) begin
            n.flue = tm_start(flue_wait);
          end
        end else begin
          n.cold_start = 1'b0;
          n.flue       = tm_clear();
        end
      end
      sdsc_pkg::ST_DYING: begin
        // Track the coldest reading while the fire dies down.
        if (temp < low_d) begin
          low_d               = temp;
          n.lowest_dying_temp = item_i.flue_temp;
        end
        if (temp > low_d + off) begin
          n.fuel   = tm_clear();
          n.beeper = sdsc_pkg::BP_OFF;
          n.drive  = sdsc_pkg::DR_IDLE;
          n.fsm    = sdsc_pkg::ST_IDLE;
        end else if (temp < tmin) begin
          n.fuel   = tm_clear();
          n.beeper = sdsc_pkg::BP_OFF;
          n.drive  = sdsc_pkg::DR_STOP;
          n.fsm    = sdsc_pkg::ST_NOFIRE;
        end else begin
          n = try_boost(n, temp < run_thr);
        end
      end
      sdsc_pkg::ST_ALARM: begin
        if (alarm_kind == sdsc_pkg::AK_NONE) begin
          n.beeper    = sdsc_pkg::BP_OFF;
          n.fan_force = 1'b0;
          n.drive     = sdsc_pkg::DR_IDLE;
          n.fsm       = sdsc_pkg::ST_IDLE;
        end
      end
      sdsc_pkg::ST_BOOST: begin
        n.boost_latched = 1'b0;
        if (n.boost.status == sdsc_pkg::TM_EXPIRED || temp >= idle_set) begin
          n.boost = tm_clear();
          n.drive = sdsc_pkg::DR_IDLE;
          n.fsm   = sdsc_pkg::ST_IDLE;
        end
      end
      default: begin
        // No fire, and any stray code, behaves as no fire.
        n.fsm        = sdsc_pkg::ST_NOFIRE;
        n.flue       = tm_clear();
        n.cold_start = 1'b1;
        if (temp >= tmin) begin
          n.drive = sdsc_pkg::DR_IDLE;
          n.fsm   = sdsc_pkg::ST_IDLE;
        end else begin
          n = try_boost(n, temp < run_thr);
        end
      end
    endcase
  end

  assign state_o = n;

  // State, drive, beeper and fan results follow the updated state.
  always_comb begin
    result_o.ctrl_state = n.fsm;
    if (n.fsm == sdsc_pkg::ST_IDLE && cfg_i.idle_override_speed != '0) begin
      result_o.drive_mode = sdsc_pkg::DM_OVERRIDE;
    end else begin
      result_o.drive_mode = sdsc_pkg::drive_mode_e'({1'b0, n.drive});
    end
    result_o.beeper_mode  = n.beeper;
    result_o.fan_force_on = n.fan_force;
    result_o.alarm_kind   = alarm_kind;
    result_o.mute_request = mute_req;
  end

endmodule

// ===== rtl/stove_draft_state_controller.sv =====
// Stove draft state controller. Throughput one item per clock while the output is not stalled;
// an input register feeds one pass of compare logic into the result register, and
// the controller state updates as the result is loaded.
// Reset is asynchronous and active low; it returns the machine to no fire, clears
// all timers and flags, and loads the configuration defaults. No clearing pass.
// Depends on sdsc_pkg and sdsc_step.
module stove_draft_state_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [sdsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sdsc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sdsc_pkg::TEMP_W-1:0]  flue_temp_i,
  input  logic                                probe_valid_i,
  input  logic                                heat_call_i,
  input  logic                                boost_button_i,
  input  logic                                mute_button_i,
  // Result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          ctrl_state_o,
  output logic [2:0]                          drive_mode_o,
  output logic [1:0]                          beeper_mode_o,
  output logic                                fan_force_on_o,
  output logic [1:0]                          alarm_kind_o,
  output logic                                mute_request_o
);

  sdsc_pkg::cfg_t        cfg_q;
  sdsc_pkg::ctrl_state_t state_q;
  sdsc_pkg::ctrl_state_t state_d;
  sdsc_pkg::item_t       item_q;
  sdsc_pkg::result_t     result_q;
  sdsc_pkg::result_t     result_d;
  logic                  s1_valid_q;
  logic                  out_valid_q;
  logic                  in_accept;
  logic                  advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_idle_temp        <= sdsc_pkg::RST_IDLE_TEMP;
      cfg_q.target_run_temp         <= sdsc_pkg::RST_RUN_TEMP;
      cfg_q.alarm_flue_temp         <= sdsc_pkg::RST_ALARM_TEMP;
      cfg_q.min_draft_temp          <= sdsc_pkg::RST_MIN_DRAFT;
      cfg_q.dying_fire_offset       <= sdsc_pkg::RST_DYING_OFF;
      cfg_q.flue_wait_seconds       <= sdsc_pkg::RST_FLUE_WAIT;
      cfg_q.cold_start_wait_seconds <= sdsc_pkg::RST_COLD_WAIT;
      cfg_q.idle_override_speed     <= sdsc_pkg::RST_IDLE_SPEED;
    end else if (cfg_we_i) begin
      unique case (sdsc_pkg::cfg_idx_e'(cfg_idx_i))
        sdsc_pkg::CFG_IDLE_TEMP:  cfg_q.target_idle_temp  <= cfg_data_i[10:0];
        sdsc_pkg::CFG_RUN_TEMP:   cfg_q.target_run_temp   <= cfg_data_i[10:0];
        sdsc_pkg::CFG_ALARM_TEMP: cfg_q.alarm_flue_temp   <= cfg_data_i[10:0];
        sdsc_pkg::CFG_MIN_DRAFT:  cfg_q.min_draft_temp    <= cfg_data_i[10:0];
        sdsc_pkg::CFG_DYING_OFF:  cfg_q.dying_fire_offset <= cfg_data_i[9:0];
        sdsc_pkg::CFG_FLUE_WAIT:  cfg_q.flue_wait_seconds <= cfg_data_i;
        sdsc_pkg::CFG_COLD_WAIT:  cfg_q.cold_start_wait_seconds <= cfg_data_i;
        sdsc_pkg::CFG_IDLE_SPEED: cfg_q.idle_override_speed <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage one moves on unless the result register holds a stalled item.
  assign advance    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.flue_temp    <= flue_temp_i;
      item_q.probe_valid  <= probe_valid_i;
      item_q.heat_call    <= heat_call_i;
      item_q.boost_button <= boost_button_i;
      item_q.mute_button  <= mute_button_i;
    end
  end

  sdsc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Controller state updates when the item's result is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.fsm               <= sdsc_pkg::ST_NOFIRE;
      state_q.cold_start        <= 1'b0;
      state_q.boost_latched     <= 1'b0;
      state_q.dying_alarm_armed <= 1'b0;
      state_q.lowest_dying_temp <= '0;
      state_q.flue.count        <= '0;
      state_q.flue.status       <= sdsc_pkg::TM_NOTSET;
      state_q.boost.count       <= '0;
      state_q.boost.status      <= sdsc_pkg::TM_NOTSET;
      state_q.fuel.count        <= '0;
      state_q.fuel.status       <= sdsc_pkg::TM_NOTSET;
      state_q.drive             <= sdsc_pkg::DR_STOP;
      state_q.beeper            <= sdsc_pkg::BP_OFF;
      state_q.fan_force         <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ctrl_state_o   = result_q.ctrl_state;
  assign drive_mode_o   = result_q.drive_mode;
  assign beeper_mode_o  = result_q.beeper_mode;
  assign fan_force_on_o = result_q.fan_force_on;
  assign alarm_kind_o   = result_q.alarm_kind;
  assign mute_request_o = result_q.mute_request;

  // The forced fan is on exactly while the machine sits in alarm.
  a_fan_matches_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fan_force_on_o == (ctrl_state_o == sdsc_pkg::ST_ALARM)))
    else $error("fan force flag disagrees with alarm state");

  // A reported alarm condition always leaves the machine in alarm.
  a_alarm_kind_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alarm_kind_o != sdsc_pkg::AK_NONE) |->
      (ctrl_state_o == sdsc_pkg::ST_ALARM))
    else $error("alarm condition reported outside alarm state");

  // In air boost the boost timer has been started.
  a_boost_timer_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.fsm == sdsc_pkg::ST_BOOST) |-> (state_q.boost.status != sdsc_pkg::TM_NOTSET))
    else $error("air boost without a boost timer");

  // An item in the input register reaches the result register unless blocked.
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !(out_valid_q && out_stall_i)) |=> out_valid_q)
    else $error("input stage item lost");

endmodule
